@@ hdl/tsir_pkg.sv @@
package tsir_pkg;

	// Field and register widths.
	localparam int WIN_W       = 10;
	localparam int COEFF_W     = 16;
	localparam int MAXSPD_W    = 14;
	localparam int GAIN_W      = 16;
	localparam int POT_W       = 10;
	localparam int DRIVE_W     = 8;
	localparam int MEAS_W      = 16;
	localparam int TARGET_W    = 14;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	// Width of the product pot_value * max_speed.
	localparam int TPROD_W = POT_W + MAXSPD_W;

	// Division of that product by 1023 is a multiply by ceil(2^34/1023) and a shift
	// by 34; the result is exact for every product below 2^24.
	localparam int RECIP_W      = 25;
	localparam int TARGET_SHIFT = 34;
	localparam logic [RECIP_W-1:0] TARGET_RECIP = 25'd16793617;

	// Default edge counter width and depth of the queue between front and back.
	localparam int EDGE_COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH_DEF      = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_COEFF  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_Q16     = 2'd3;

	// Register reset values.
	localparam logic [WIN_W-1:0]    WINDOW_TICKS_RST = 10'd100;
	localparam logic [COEFF_W-1:0]  SPEED_COEFF_RST  = 16'd7500;
	localparam logic [MAXSPD_W-1:0] MAX_SPEED_RST    = 14'd8000;
	localparam logic [GAIN_W-1:0]   GAIN_Q16_RST     = 16'd1044;

	// Full scale of the potentiometer converter, the divisor of the target speed.
	localparam logic [WIN_W-1:0] POT_FULL_SCALE = 10'd1023;

	// Back end sequencer states.
	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MUL1  = 10'b00_0000_0010,
		ST_D1GO  = 10'b00_0000_0100,
		ST_D1WT  = 10'b00_0000_1000,
		ST_MUL2  = 10'b00_0001_0000,
		ST_TGT   = 10'b00_0010_0000,
		ST_DIFF  = 10'b00_0100_0000,
		ST_MULG  = 10'b00_1000_0000,
		ST_DRIVE = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} back_state_t;

endpackage

@@ hdl/tsir_front.sv @@
module tsir_front #(
	parameter int EDGE_W = tsir_pkg::EDGE_COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           sensor_level,
	input  logic                           ms_tick,
	input  logic [tsir_pkg::POT_W-1:0]     pot_value,
	input  logic [tsir_pkg::WIN_W-1:0]     window_ticks,
	input  logic                           queue_full,
	output logic                           push,
	output logic [EDGE_W+tsir_pkg::POT_W-1:0] push_data
);

	logic                       sensor_prev_q;
	logic [EDGE_W-1:0]          edges_q;
	logic [tsir_pkg::WIN_W-1:0] ticks_q;

	logic                       accept;
	logic                       edge_seen;
	logic [EDGE_W-1:0]          edges_nx;
	logic [tsir_pkg::WIN_W-1:0] ticks_nx;
	logic [tsir_pkg::WIN_W-1:0] win;
	logic                       close;

	// Samples are taken every cycle unless the queue to the back end is full.
	assign in_stall = queue_full;
	assign accept   = in_valid & ~queue_full;

	// A window of zero ticks acts as a window of one tick.
	assign win = (window_ticks == '0) ? tsir_pkg::WIN_W'(1) : window_ticks;

	// The edge counts first, saturating; then the tick; then the window check.
	assign edge_seen = sensor_level ^ sensor_prev_q;
	assign edges_nx  = (edge_seen && (edges_q != '1)) ? edges_q + 1'b1 : edges_q;
	assign ticks_nx  = ms_tick ? ticks_q + 1'b1 : ticks_q;
	assign close     = (ticks_nx >= win);

	// A closing beat hands its edge count and pot reading to the back end.
	assign push      = accept & close;
	assign push_data = {edges_nx, pot_value};

	// Sensor history and the two window counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_prev_q <= 1'b0;
			edges_q       <= '0;
			ticks_q       <= '0;
		end else if (accept) begin
			sensor_prev_q <= sensor_level;
			if (close) begin
				edges_q <= '0;
				ticks_q <= '0;
			end else begin
				edges_q <= edges_nx;
				ticks_q <= ticks_nx;
			end
		end
	end

endmodule

@@ hdl/tsir_queue.sv @@
module tsir_queue #(
	parameter int WIDTH = 26,
	parameter int DEPTH = tsir_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/tsir_div.sv @@
module tsir_div #(
	parameter int DIVIDEND_W = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [DIVIDEND_W-1:0]      dividend,
	input  logic [tsir_pkg::WIN_W-1:0] divisor,
	output logic                       done,
	output logic [DIVIDEND_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0]      acc_q;
	logic [tsir_pkg::WIN_W-1:0] rem_q;
	logic [tsir_pkg::WIN_W-1:0] dsr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [tsir_pkg::WIN_W:0]   trial;
	logic                       fits;

	// One restoring step: bring down the next dividend bit and try the divisor.
	assign trial = {rem_q, acc_q[DIVIDEND_W-1]};
	assign fits  = (trial >= {1'b0, dsr_q});

	assign done     = done_q;
	assign quotient = acc_q;

	// Datapath: the quotient bits shift in where the dividend bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? tsir_pkg::WIN_W'(trial - {1'b0, dsr_q})
			              : trial[tsir_pkg::WIN_W-1:0];
		end
	end

	// Step counter; done pulses for one cycle after the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DIVIDEND_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ hdl/tsir_back.sv @@
module tsir_back #(
	parameter int EDGE_W = tsir_pkg::EDGE_COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              queue_empty,
	input  logic [EDGE_W+tsir_pkg::POT_W-1:0] pop_data,
	output logic                              pop,
	input  logic [tsir_pkg::WIN_W-1:0]        window_ticks,
	input  logic [tsir_pkg::COEFF_W-1:0]      speed_coeff,
	input  logic [tsir_pkg::MAXSPD_W-1:0]     max_speed,
	input  logic [tsir_pkg::GAIN_W-1:0]       gain_q16,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tsir_pkg::DRIVE_W-1:0]      drive_level,
	output logic [tsir_pkg::MEAS_W-1:0]       measured_rpm,
	output logic [tsir_pkg::TARGET_W-1:0]     target_rpm
);

	localparam int PROD_W = tsir_pkg::COEFF_W + EDGE_W;
	localparam int STEP_W = tsir_pkg::MEAS_W;
	localparam int GPROD_W = STEP_W + tsir_pkg::GAIN_W;
	localparam int RPROD_W = tsir_pkg::TPROD_W + tsir_pkg::RECIP_W;

	tsir_pkg::back_state_t state_q;

	logic [EDGE_W-1:0]             edges_q;
	logic [tsir_pkg::POT_W-1:0]    pot_q;
	logic [PROD_W-1:0]             prod_q;
	logic [tsir_pkg::MEAS_W-1:0]   measured_q;
	logic [tsir_pkg::TARGET_W-1:0] target_q;
	logic [STEP_W-1:0]             diff_q;
	logic                          up_q;
	logic [STEP_W-1:0]             step_q;
	logic [tsir_pkg::DRIVE_W-1:0]  drive_q;
	logic                          out_valid_q;
	logic [tsir_pkg::DRIVE_W-1:0]  out_drive_q;
	logic [tsir_pkg::MEAS_W-1:0]   out_meas_q;
	logic [tsir_pkg::TARGET_W-1:0] out_target_q;

	logic [PROD_W-1:0]             mul_a;
	logic [PROD_W-1:0]             mul_b;
	logic [tsir_pkg::TPROD_W-1:0]  tprod;
	logic [RPROD_W-1:0]            rprod;
	logic [GPROD_W-1:0]            gprod;
	logic [tsir_pkg::MEAS_W-1:0]   target_ext;
	logic [tsir_pkg::WIN_W-1:0]    win;
	logic                          div_start;
	logic                          div_done;
	logic [PROD_W-1:0]             div_quot;
	logic [tsir_pkg::DRIVE_W:0]    drive_up;
	logic [tsir_pkg::DRIVE_W-1:0]  drive_nx;
	logic                          out_free;

	// Products of the multiply steps.
	assign mul_a = PROD_W'(speed_coeff);
	assign mul_b = PROD_W'(edges_q);
	assign tprod = tsir_pkg::TPROD_W'(pot_q) * tsir_pkg::TPROD_W'(max_speed);
	assign gprod = GPROD_W'(diff_q) * GPROD_W'(gain_q16);

	// Target speed: the registered pot product times the reciprocal of 1023.
	assign rprod = RPROD_W'(prod_q[tsir_pkg::TPROD_W-1:0]) * RPROD_W'(tsir_pkg::TARGET_RECIP);

	assign win = (window_ticks == '0) ? tsir_pkg::WIN_W'(1) : window_ticks;
	assign target_ext = tsir_pkg::MEAS_W'(target_q);

	// The divider serves the measured speed quotient.
	assign div_start = (state_q == tsir_pkg::ST_D1GO);

	tsir_div #(
		.DIVIDEND_W (PROD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (win),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Drive step toward the target, clamped to the drive range.
	assign drive_up = {1'b0, drive_q} + tsir_pkg::DRIVE_W'(1'b0) + ((step_q > STEP_W'(255))
	                  ? (tsir_pkg::DRIVE_W + 1)'(256) : (tsir_pkg::DRIVE_W + 1)'(step_q));

	always_comb begin
		if (up_q) begin
			drive_nx = drive_up[tsir_pkg::DRIVE_W] ? '1 : drive_up[tsir_pkg::DRIVE_W-1:0];
		end else if (step_q > STEP_W'(drive_q)) begin
			drive_nx = '0;
		end else begin
			drive_nx = drive_q - step_q[tsir_pkg::DRIVE_W-1:0];
		end
	end

	assign pop      = (state_q == tsir_pkg::ST_IDLE) && !queue_empty;
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign drive_level  = out_drive_q;
	assign measured_rpm = out_meas_q;
	assign target_rpm   = out_target_q;

	// Working registers of the window computation.
	always_ff @(posedge clk) begin
		unique case (state_q)
			tsir_pkg::ST_IDLE: begin
				edges_q <= pop_data[EDGE_W+tsir_pkg::POT_W-1:tsir_pkg::POT_W];
				pot_q   <= pop_data[tsir_pkg::POT_W-1:0];
			end
			tsir_pkg::ST_MUL1: begin
				prod_q <= mul_a * mul_b;
			end
			tsir_pkg::ST_D1WT: begin
				measured_q <= (div_quot > PROD_W'(16'hFFFF)) ? '1
				              : div_quot[tsir_pkg::MEAS_W-1:0];
			end
			tsir_pkg::ST_MUL2: begin
				prod_q <= PROD_W'(tprod);
			end
			tsir_pkg::ST_TGT: begin
				target_q <= rprod[tsir_pkg::TARGET_SHIFT +: tsir_pkg::TARGET_W];
			end
			tsir_pkg::ST_DIFF: begin
				up_q   <= (target_ext > measured_q);
				diff_q <= (target_ext > measured_q) ? target_ext - measured_q
				          : measured_q - target_ext;
			end
			tsir_pkg::ST_MULG: begin
				step_q <= gprod[GPROD_W-1:tsir_pkg::GAIN_W];
			end
			tsir_pkg::ST_OUT: begin
				if (out_free) begin
					out_drive_q  <= drive_q;
					out_meas_q   <= measured_q;
					out_target_q <= target_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, drive state and the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tsir_pkg::ST_IDLE;
			drive_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output beat is raised when a result is ready and dropped once taken.
			if ((state_q == tsir_pkg::ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				tsir_pkg::ST_IDLE: begin
					if (!queue_empty) begin
						state_q <= tsir_pkg::ST_MUL1;
					end
				end
				tsir_pkg::ST_MUL1: state_q <= tsir_pkg::ST_D1GO;
				tsir_pkg::ST_D1GO: state_q <= tsir_pkg::ST_D1WT;
				tsir_pkg::ST_D1WT: begin
					if (div_done) begin
						state_q <= tsir_pkg::ST_MUL2;
					end
				end
				tsir_pkg::ST_MUL2: state_q <= tsir_pkg::ST_TGT;
				tsir_pkg::ST_TGT:  state_q <= tsir_pkg::ST_DIFF;
				tsir_pkg::ST_DIFF: state_q <= tsir_pkg::ST_MULG;
				tsir_pkg::ST_MULG: state_q <= tsir_pkg::ST_DRIVE;
				tsir_pkg::ST_DRIVE: begin
					// Equal speeds give a zero step and leave the drive as it is.
					drive_q <= drive_nx;
					state_q <= tsir_pkg::ST_OUT;
				end
				tsir_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= tsir_pkg::ST_IDLE;
					end
				end
				default: state_q <= tsir_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

@@ hdl/tacho_speed_integral_regulator_top.sv @@
// Tachometer speed regulator. Each input beat is one sample (sensor level, millisecond
// tick, potentiometer reading); samples are taken one per cycle and the front end counts
// sensor level changes (saturating) and ticks. When the tick count reaches window_ticks,
// the edge count and pot reading go through a two-entry queue to the back end, which
// computes measured_rpm = floor(speed_coeff*edges/window) saturated at 65535, target_rpm =
// floor(pot*max_speed/1023), steps the drive by floor(|error|*gain_q16/65536) toward the
// target, clamps it to 0..255 and emits one output beat. The back end pops a new window
// only once it has finished the one before; the measured speed comes from a
// one-bit-per-cycle divider and the target speed from one reciprocal multiply.
// Samples are stalled only while the queue is full. Configuration writes take
// effect at once and are meant for idle times.
module tacho_speed_integral_regulator_top #(
	parameter int EDGE_COUNT_WIDTH = tsir_pkg::EDGE_COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tsir_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tsir_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             sensor_level,
	input  logic                             ms_tick,
	input  logic [tsir_pkg::POT_W-1:0]       pot_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tsir_pkg::DRIVE_W-1:0]     drive_level,
	output logic [tsir_pkg::MEAS_W-1:0]      measured_rpm,
	output logic [tsir_pkg::TARGET_W-1:0]    target_rpm
);

	localparam int ENTRY_W = EDGE_COUNT_WIDTH + tsir_pkg::POT_W;

	logic [tsir_pkg::WIN_W-1:0]    window_ticks_q;
	logic [tsir_pkg::COEFF_W-1:0]  speed_coeff_q;
	logic [tsir_pkg::MAXSPD_W-1:0] max_speed_q;
	logic [tsir_pkg::GAIN_W-1:0]   gain_q16_q;

	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic [ENTRY_W-1:0] pop_data;
	logic               queue_full;
	logic               queue_empty;

	// Configuration registers; written values are masked to the register width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q <= tsir_pkg::WINDOW_TICKS_RST;
			speed_coeff_q  <= tsir_pkg::SPEED_COEFF_RST;
			max_speed_q    <= tsir_pkg::MAX_SPEED_RST;
			gain_q16_q     <= tsir_pkg::GAIN_Q16_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsir_pkg::REG_WINDOW_TICKS: window_ticks_q <= cfg_data[tsir_pkg::WIN_W-1:0];
				tsir_pkg::REG_SPEED_COEFF:  speed_coeff_q  <= cfg_data[tsir_pkg::COEFF_W-1:0];
				tsir_pkg::REG_MAX_SPEED:    max_speed_q    <= cfg_data[tsir_pkg::MAXSPD_W-1:0];
				tsir_pkg::REG_GAIN_Q16:     gain_q16_q     <= cfg_data[tsir_pkg::GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sample intake and window detection.
	tsir_front #(
		.EDGE_W (EDGE_COUNT_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sensor_level (sensor_level),
		.ms_tick      (ms_tick),
		.pot_value    (pot_value),
		.window_ticks (window_ticks_q),
		.queue_full   (queue_full),
		.push         (push),
		.push_data    (push_data)
	);

	// Closed windows waiting for the back end.
	tsir_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (tsir_pkg::QUEUE_DEPTH_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// Speed computation and drive regulation.
	tsir_back #(
		.EDGE_W (EDGE_COUNT_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.window_ticks (window_ticks_q),
		.speed_coeff  (speed_coeff_q),
		.max_speed    (max_speed_q),
		.gain_q16     (gain_q16_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_level  (drive_level),
		.measured_rpm (measured_rpm),
		.target_rpm   (target_rpm)
	);

endmodule

@@ tb/tacho_speed_integral_regulator_top_tb.sv @@
`timescale 1ns / 1ps

module tacho_speed_integral_regulator_top_tb;

	localparam int EDGE_W        = tsir_pkg::EDGE_COUNT_WIDTH_DEF;
	localparam int DUTY_MAX      = (1 << tsir_pkg::DRIVE_W) - 1;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 150;

	// One sensor sample; chk marks a sample whose speed beat is typed in by hand.
	typedef struct {
		logic                          level;
		logic                          tick;
		logic [tsir_pkg::POT_W-1:0]    pot;
		bit                            chk;
		logic [tsir_pkg::DRIVE_W-1:0]  drive;
		logic [tsir_pkg::MEAS_W-1:0]   meas;
		logic [tsir_pkg::TARGET_W-1:0] target;
	} sample_t;

	typedef struct {
		logic [tsir_pkg::DRIVE_W-1:0]  drive;
		logic [tsir_pkg::MEAS_W-1:0]   meas;
		logic [tsir_pkg::TARGET_W-1:0] target;
	} speed_beat_t;

	typedef enum bit {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t                        kind;
		logic [tsir_pkg::CFG_INDEX_W-1:0] idx;
		logic [tsir_pkg::CFG_DATA_W-1:0]  data;
		logic                             level;
		logic                             tick;
		logic [tsir_pkg::POT_W-1:0]       pot;
		bit                               chk;
		logic [tsir_pkg::DRIVE_W-1:0]     drive;
		logic [tsir_pkg::MEAS_W-1:0]      meas;
		logic [tsir_pkg::TARGET_W-1:0]    target;
	} row_t;

	// Directed rows: register extremes, masking, zero window, saturation and the
	// edge that lands on the closing sample.
	row_t directed_rows [24] = '{
		'{ROW_CFG,    tsir_pkg::REG_WINDOW_TICKS, 16'd1,    0, 0, 0,    0, 0,   0,     0},
		'{ROW_CFG,    tsir_pkg::REG_SPEED_COEFF,  16'd60000, 0, 0, 0,   0, 0,   0,     0},
		'{ROW_CFG,    tsir_pkg::REG_MAX_SPEED,    16'd16000, 0, 0, 0,   0, 0,   0,     0},
		'{ROW_CFG,    tsir_pkg::REG_GAIN_Q16,     16'd65535, 0, 0, 0,   0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    1, 1, 1023, 1, 0,   60000, 16000},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    0, 1, 0,    1, 0,   60000, 0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    0, 1, 1023, 1, 255, 0,     16000},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    1, 0, 512,  0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    0, 1, 512,  0, 0,   0,     0},
		'{ROW_CFG,    tsir_pkg::REG_GAIN_Q16,     16'd0,    0, 0, 0,    0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    1, 1, 1023, 1, 0,   60000, 16000},
		'{ROW_CFG,    tsir_pkg::REG_WINDOW_TICKS, 16'h0400, 0, 0, 0,    0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    1, 1, 1023, 1, 0,   0,     16000},
		'{ROW_CFG,    tsir_pkg::REG_MAX_SPEED,    16'hC001, 0, 0, 0,    0, 0,   0,     0},
		'{ROW_CFG,    tsir_pkg::REG_GAIN_Q16,     16'hFFFF, 0, 0, 0,    0, 0,   0,     0},
		'{ROW_CFG,    tsir_pkg::REG_SPEED_COEFF,  16'd1,    0, 0, 0,    0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    0, 1, 1023, 1, 0,   1,     1},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    0, 1, 1022, 1, 0,   0,     0},
		'{ROW_CFG,    tsir_pkg::REG_WINDOW_TICKS, 16'hFC03, 0, 0, 0,    0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    1, 0, 1023, 0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    0, 1, 1023, 0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    1, 0, 1023, 0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    1, 1, 1023, 0, 0,   0,     0},
		'{ROW_SAMPLE, tsir_pkg::REG_WINDOW_TICKS, 16'd0,    0, 1, 1023, 0, 0,   0,     0}
	};

	logic                             clk          = 1'b0;
	logic                             arst_n       = 1'b0;
	logic                             cfg_we       = 1'b0;
	logic [tsir_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [tsir_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                             in_valid     = 1'b0;
	logic                             in_stall;
	logic                             sensor_level = 1'b0;
	logic                             ms_tick      = 1'b0;
	logic [tsir_pkg::POT_W-1:0]       pot_value    = '0;
	logic                             out_valid;
	logic                             out_stall    = 1'b0;
	logic [tsir_pkg::DRIVE_W-1:0]     drive_level;
	logic [tsir_pkg::MEAS_W-1:0]      measured_rpm;
	logic [tsir_pkg::TARGET_W-1:0]    target_rpm;

	// Regulator model state and its copy of the registers.
	logic                          prev_level;
	logic [EDGE_W-1:0]             edge_total;
	logic [tsir_pkg::WIN_W-1:0]    tick_total;
	logic [tsir_pkg::DRIVE_W-1:0]  duty;
	logic [tsir_pkg::WIN_W-1:0]    win_reg;
	logic [tsir_pkg::COEFF_W-1:0]  coeff_reg;
	logic [tsir_pkg::MAXSPD_W-1:0] maxspd_reg;
	logic [tsir_pkg::GAIN_W-1:0]   gain_reg;

	sample_t     sample_q [$];
	sample_t     offered;
	speed_beat_t speed_q [$];
	longint      queued_count   = 0;
	longint      accepted_count = 0;
	int          burst_left     = 1;
	int          gap_left       = 0;
	bit          hold_ask       = 1'b0;
	int          hold_left      = 0;
	int          seg_left       = 0;
	int          stall_pct      = 0;
	int          fault_count    = 0;

	tacho_speed_integral_regulator_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sensor_level (sensor_level),
		.ms_tick      (ms_tick),
		.pot_value    (pot_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_level  (drive_level),
		.measured_rpm (measured_rpm),
		.target_rpm   (target_rpm)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advances the regulator model by one sample; returns 1 when a window closes.
	function automatic bit regulate(input sample_t s, output speed_beat_t r);
		logic [tsir_pkg::WIN_W-1:0] win;
		longint unsigned            meas;
		longint unsigned            tgt;
		longint unsigned            step;
		int                         duty_next;
		r = '{default: '0};
		if (s.level != prev_level) begin
			if (edge_total != '1)
				edge_total++;
			prev_level = s.level;
		end
		if (s.tick)
			tick_total++;
		win = (win_reg == '0) ? tsir_pkg::WIN_W'(1) : win_reg;
		if (tick_total < win)
			return 1'b0;
		meas = 64'(coeff_reg) * 64'(edge_total) / 64'(win);
		if (meas > 64'hFFFF)
			meas = 64'hFFFF;
		tgt = 64'(s.pot) * 64'(maxspd_reg) / 64'(tsir_pkg::POT_FULL_SCALE);
		duty_next = int'(duty);
		// Step toward the target by the scaled error, clamped to the duty range.
		if (tgt > meas) begin
			step = ((tgt - meas) * 64'(gain_reg)) >> 16;
			duty_next = duty_next + int'(step);
			if (duty_next > DUTY_MAX)
				duty_next = DUTY_MAX;
		end else if (tgt < meas) begin
			step = ((meas - tgt) * 64'(gain_reg)) >> 16;
			duty_next = duty_next - int'(step);
			if (duty_next < 0)
				duty_next = 0;
		end
		duty = tsir_pkg::DRIVE_W'(duty_next);
		edge_total = '0;
		tick_total = '0;
		r.drive = duty;
		r.meas = tsir_pkg::MEAS_W'(meas);
		r.target = tsir_pkg::TARGET_W'(tgt);
		return 1'b1;
	endfunction

	function automatic void enqueue(input sample_t s);
		sample_q.push_back(s);
		queued_count++;
	endfunction

	function automatic logic [tsir_pkg::POT_W-1:0] rand_pot();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return tsir_pkg::POT_W'($urandom_range(0, 1023));
		endcase
	endfunction

	// Waits until every sample is taken and every speed beat has come, then lets
	// the back end settle before the register is written.
	task automatic write_reg(input logic [tsir_pkg::CFG_INDEX_W-1:0] idx,
			input logic [tsir_pkg::CFG_DATA_W-1:0] data);
		while (!(accepted_count == queued_count && speed_q.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			tsir_pkg::REG_WINDOW_TICKS: win_reg = data[tsir_pkg::WIN_W-1:0];
			tsir_pkg::REG_SPEED_COEFF: coeff_reg = data[tsir_pkg::COEFF_W-1:0];
			tsir_pkg::REG_MAX_SPEED: maxspd_reg = data[tsir_pkg::MAXSPD_W-1:0];
			tsir_pkg::REG_GAIN_Q16: gain_reg = data[tsir_pkg::GAIN_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sample sender: bursts of random length with random gaps between them.
	always @(posedge clk) begin : sender
		speed_beat_t beat;
		bit          produced;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				accepted_count++;
				produced = regulate(offered, beat);
				if (offered.chk)
					beat = '{offered.drive, offered.meas, offered.target};
				if (produced || offered.chk)
					speed_q.push_back(beat);
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					offered = sample_q.pop_front();
					in_valid <= 1'b1;
					sensor_level <= offered.level;
					ms_tick <= offered.tick;
					pot_value <= offered.pot;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Speed beat receiver: checks each beat, then picks the stall for the next cycle.
	always @(posedge clk) begin : receiver
		speed_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (speed_q.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("Unexpected beat: drive %0d measured %0d target %0d",
						drive_level, measured_rpm, target_rpm);
			end else begin
				want = speed_q.pop_front();
				if (drive_level !== want.drive || measured_rpm !== want.meas ||
						target_rpm !== want.target) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("Mismatch: drive %0d/%0d measured %0d/%0d target %0d/%0d %s",
							drive_level, want.drive, measured_rpm, want.meas,
							target_rpm, want.target, "(actual/expected)");
				end
			end
		end
		// A requested hold-off keeps the output stalled until the hold count runs out.
		if (hold_ask) begin
			hold_ask = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 300);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			seg_left--;
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin : stimulus
		logic [tsir_pkg::CFG_DATA_W-1:0] d;
		logic [tsir_pkg::WIN_W-1:0]      w;
		logic                            lvl;
		int                              tick_pct;
		win_reg = tsir_pkg::WINDOW_TICKS_RST;
		coeff_reg = tsir_pkg::SPEED_COEFF_RST;
		maxspd_reg = tsir_pkg::MAX_SPEED_RST;
		gain_reg = tsir_pkg::GAIN_Q16_RST;
		prev_level = 1'b0;
		edge_total = '0;
		tick_total = '0;
		duty = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: 100 ticks with an edge on each, full pot.
		for (int i = 0; i < 100; i++)
			enqueue('{!i[0], 1'b1, 10'd1023, (i == 99), 8'd7, 16'd7500, 14'd8000});

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG)
				write_reg(directed_rows[r].idx, directed_rows[r].data);
			else
				enqueue('{directed_rows[r].level, directed_rows[r].tick,
					directed_rows[r].pot, directed_rows[r].chk, directed_rows[r].drive,
					directed_rows[r].meas, directed_rows[r].target});
		end

		// A longer window, then a window lowered below the running tick count.
		write_reg(tsir_pkg::REG_WINDOW_TICKS, 16'd20);
		write_reg(tsir_pkg::REG_SPEED_COEFF, 16'(tsir_pkg::SPEED_COEFF_RST));
		write_reg(tsir_pkg::REG_MAX_SPEED, 16'(tsir_pkg::MAX_SPEED_RST));
		write_reg(tsir_pkg::REG_GAIN_Q16, 16'(tsir_pkg::GAIN_Q16_RST));
		for (int i = 0; i < 26; i++)
			enqueue('{1'($urandom_range(0, 1)), 1'b1, rand_pot(), 1'b0, '0, '0, '0});
		write_reg(tsir_pkg::REG_WINDOW_TICKS, 16'd4);
		enqueue('{1'($urandom_range(0, 1)), 1'b0, rand_pot(), 1'b0, '0, '0, '0});

		// Random phases, each with fresh register settings; the first holds off
		// the receiver so the block fills up and stalls its input.
		lvl = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			w = ($urandom_range(0, 5) == 0) ? '0 : tsir_pkg::WIN_W'($urandom_range(1, 8));
			if (p == 0)
				w = tsir_pkg::WIN_W'(1);
			write_reg(tsir_pkg::REG_WINDOW_TICKS, {6'($urandom), w});
			case ($urandom_range(0, 5))
				0: d = 16'd1;
				1: d = 16'd60000;
				2: d = '1;
				3: d = '0;
				default: d = 16'($urandom_range(1, 3000));
			endcase
			write_reg(tsir_pkg::REG_SPEED_COEFF, d);
			case ($urandom_range(0, 3))
				0: d = 16'd16000;
				1: d = 16'($urandom);
				default: d = 16'($urandom_range(1, 16000));
			endcase
			write_reg(tsir_pkg::REG_MAX_SPEED, d);
			case ($urandom_range(0, 4))
				0: d = '0;
				1: d = '1;
				default: d = 16'($urandom_range(0, 3000));
			endcase
			write_reg(tsir_pkg::REG_GAIN_Q16, d);
			tick_pct = (p == 0) ? 95 : $urandom_range(20, 90);
			if (p == 0)
				hold_ask = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 40)
					lvl = !lvl;
				enqueue('{lvl, ($urandom_range(0, 99) < tick_pct), rand_pot(),
					1'b0, '0, '0, '0});
			end
		end

		while (!(accepted_count == queued_count && speed_q.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && speed_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Run limit, well above the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
